>>> src/fqrc_pkg.sv
// Package with the shared constants and types of the frame quality rate control unit.
package fqrc_pkg;

  localparam int unsigned QualW = 7;
  localparam int unsigned TargetW = 9;
  localparam int unsigned SizeW = 24;
  localparam int unsigned StepW = 3;
  localparam int unsigned CmdW = 2;
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned CfgDataW = 9;

  localparam logic [QualW-1:0] QualFloor = 7'd30;
  localparam logic [StepW-1:0] FirstStep = 3'd4;
  localparam logic [QualW-1:0] MaxQualityReset = 7'd90;
  localparam logic [TargetW-1:0] TargetKibReset = 9'd0;

  localparam logic [CmdW-1:0] CMD_START = 2'd0;
  localparam logic [CmdW-1:0] CMD_FAILED = 2'd1;
  localparam logic [CmdW-1:0] CMD_TRIAL = 2'd2;

  localparam logic [CfgIdxW-1:0] CFG_MAX_QUALITY = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_TARGET_KIB = 1'b1;

  localparam logic [1:0] SEEN_UP = 2'b01;
  localparam logic [1:0] SEEN_DOWN = 2'b10;

  typedef struct packed {
    logic [CmdW-1:0]  cmd;
    logic [SizeW-1:0] compressed_size;
  } in_item_t;

  typedef struct packed {
    logic [QualW-1:0] quality;
    logic             finished;
  } out_item_t;

endpackage

>>> src/fqrc_if.sv
// Valid/ready channel interfaces for the command input and the quality result.
interface fqrc_in_if import fqrc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CmdW-1:0]  cmd;
  logic [SizeW-1:0] compressed_size;

  modport source (output valid, output cmd, output compressed_size, input ready);
  modport sink (input valid, input cmd, input compressed_size, output ready);
endinterface

interface fqrc_out_if import fqrc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [QualW-1:0] quality;
  logic             finished;

  modport source (output valid, output quality, output finished, input ready);
  modport sink (input valid, input quality, input finished, output ready);
endinterface

>>> src/frame_quality_rate_control_unit.sv
// Top level of the frame quality rate control unit: quality search per frame.
//
// Channel   Direction  Payload                         Transaction
// in_i      sink       cmd, compressed_size            valid & ready at clk_i edge
// out_o     source     quality, finished               valid & ready at clk_i edge
// cfg       write      cfg_we_i, cfg_idx_i, cfg_wdata_i  cfg_we_i at clk_i edge
//
// Each command passes through an input register, then through one pass of
// compares and small adds into the result register.
// One command is accepted every cycle while the result side keeps taking.
// A stalled result holds, and one more command may wait in the input register.
// Reset restores max_quality 90, target 0 and the search state of a fresh frame.
module frame_quality_rate_control_unit
  import fqrc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  fqrc_in_if.sink             in_i,
  fqrc_out_if.source          out_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i
);

  function automatic logic [QualW-1:0] sat_add(logic [QualW-1:0] q, logic [StepW-1:0] d);
    logic [QualW:0] s;
    s = {1'b0, q} + {{(QualW+1-StepW){1'b0}}, d};
    return s[QualW] ? {QualW{1'b1}} : s[QualW-1:0];
  endfunction

  function automatic logic [QualW-1:0] sat_sub(logic [QualW-1:0] q, logic [StepW-1:0] d);
    logic [QualW:0] s;
    s = {1'b0, q} - {{(QualW+1-StepW){1'b0}}, d};
    return s[QualW] ? '0 : s[QualW-1:0];
  endfunction

  logic [QualW-1:0]   max_q;
  logic [TargetW-1:0] target_q;
  logic [QualW-1:0]   cur_q, cur_d;
  logic [QualW-1:0]   last_q, last_d;
  logic [StepW-1:0]   step_q, step_d;
  logic [1:0]         seen_q, seen_d;
  logic               retry_q, retry_d;

  logic      in_v_q;
  in_item_t  in_q;
  logic      out_v_q;
  out_item_t out_q, out_d;
  logic      adv;
  logic      in_ready;

  assign adv = in_v_q && (!out_v_q || out_o.ready);
  assign in_ready = !in_v_q || adv;
  assign in_i.ready = in_ready;
  assign out_o.valid = out_v_q;
  assign out_o.quality = out_q.quality;
  assign out_o.finished = out_q.finished;

  always_comb begin
    logic [QualW-1:0]   q;
    logic [18:0]        tgt;
    logic [27:0]        s10;
    logic [27:0]        t9;
    logic [27:0]        t11;
    logic               below;
    logic               above;
    logic               done;
    logic [1:0]         seen_n;
    logic [StepW-1:0]   step_n;
    q = cur_q;
    tgt = {target_q, 10'b0};
    s10 = 28'(in_q.compressed_size) * 28'd10;
    t9 = 28'(tgt) * 28'd9;
    t11 = 28'(tgt) * 28'd11;
    below = s10 < t9;
    above = s10 > t11;
    done = 1'b0;
    seen_n = seen_q;
    step_n = step_q;
    cur_d = cur_q;
    last_d = last_q;
    step_d = step_q;
    seen_d = seen_q;
    retry_d = retry_q;
    out_d.quality = cur_q;
    out_d.finished = 1'b0;
    unique case (in_q.cmd)
      CMD_START: begin
        if (target_q == '0) begin
          q = max_q;
        end else begin
          q = (cur_q > max_q) ? max_q : cur_q;
          q = (q < QualFloor) ? QualFloor : q;
          step_d = FirstStep;
          seen_d = '0;
        end
        cur_d = q;
        last_d = q;
        retry_d = 1'b0;
        out_d.quality = q;
      end
      CMD_FAILED: begin
        q = sat_sub(cur_q, StepW'(1));
        cur_d = q;
        retry_d = 1'b1;
        out_d.quality = q;
      end
      CMD_TRIAL: begin
        if (target_q == '0) begin
          out_d.finished = 1'b1;
        end else begin
          if (below) begin
            if (retry_q) begin
              q = last_q;
              done = 1'b1;
            end else if (cur_q == max_q) begin
              done = 1'b1;
            end else begin
              seen_n = seen_q | SEEN_UP;
              if (seen_n == (SEEN_UP | SEEN_DOWN)) begin
                step_n = step_q >> 1;
              end
              q = sat_add(cur_q, step_n);
            end
          end else if (above) begin
            if (cur_q == QualFloor) begin
              done = 1'b1;
            end else begin
              seen_n = seen_q | SEEN_DOWN;
              if (seen_n == (SEEN_UP | SEEN_DOWN)) begin
                step_n = step_q >> 1;
              end
              q = sat_sub(cur_q, step_n);
            end
          end else begin
            done = 1'b1;
          end
          if (!done && step_n == '0) begin
            if (s10 < t11) begin
              done = 1'b1;
            end else begin
              q = sat_sub(q, StepW'(1));
            end
          end
          seen_d = seen_n;
          step_d = step_n;
          if (done) begin
            out_d.quality = q;
            out_d.finished = 1'b1;
            if (in_q.compressed_size < 24'(tgt)) begin
              cur_d = sat_add(q, StepW'(1));
            end else begin
              cur_d = sat_sub(q, StepW'(1));
            end
          end else begin
            q = (q > max_q) ? max_q : q;
            q = (q < QualFloor) ? QualFloor : q;
            cur_d = q;
            last_d = q;
            retry_d = 1'b0;
            out_d.quality = q;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q <= MaxQualityReset;
      target_q <= TargetKibReset;
      cur_q <= MaxQualityReset;
      last_q <= MaxQualityReset;
      step_q <= FirstStep;
      seen_q <= '0;
      retry_q <= 1'b0;
      in_v_q <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_MAX_QUALITY: max_q <= cfg_wdata_i[QualW-1:0];
          CFG_TARGET_KIB: target_q <= cfg_wdata_i[TargetW-1:0];
          default: begin
          end
        endcase
      end
      if (in_ready) begin
        in_v_q <= in_i.valid;
      end
      if (adv) begin
        cur_q <= cur_d;
        last_q <= last_d;
        step_q <= step_d;
        seen_q <= seen_d;
        retry_q <= retry_d;
        out_v_q <= 1'b1;
      end else if (out_o.ready) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && in_i.valid) begin
      in_q.cmd <= in_i.cmd;
      in_q.compressed_size <= in_i.compressed_size;
    end
    if (adv) begin
      out_q <= out_d;
    end
  end

  a_step_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_q <= FirstStep)
    else $error("quality step above its start value");

  a_start_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && in_q.cmd == CMD_START && target_q != '0 |=> step_q == FirstStep && seen_q == '0)
    else $error("start of frame did not restart the search");

  a_fail_marks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && in_q.cmd == CMD_FAILED |=> retry_q && out_v_q && !out_q.finished)
    else $error("compressor failure not recorded");

  a_stall_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready |-> in_v_q && out_v_q && !out_o.ready)
    else $error("input held off without a stalled result");

endmodule
